@@ rtl/anc_pkg.sv @@
// ----------------------------------------------------------------------------
// anc_pkg: shared types and constants of the neighbour classifier
// Item and result layouts, mode codes and mask bit positions.
// ----------------------------------------------------------------------------
package anc_pkg;

  localparam int unsigned IdW      = 8;
  localparam int unsigned NbrCount = 8;
  localparam int unsigned IndexW   = 6;

  // Mask bit positions: sides first, then corners.
  localparam int unsigned BitT  = 0;
  localparam int unsigned BitR  = 1;
  localparam int unsigned BitB  = 2;
  localparam int unsigned BitL  = 3;
  localparam int unsigned BitTl = 4;
  localparam int unsigned BitTr = 5;
  localparam int unsigned BitBr = 6;
  localparam int unsigned BitBl = 7;

  typedef enum logic {
    KIND_FOUR  = 1'b0,
    KIND_EIGHT = 1'b1
  } anc_kind_e;

  typedef struct packed {
    anc_kind_e                          kind;
    logic [NbrCount-1:0][IdW-1:0]       nbr_ids;   // index follows mask bit order
    logic [NbrCount-1:0]                inside_mask;
    logic [IdW-1:0]                     match_id;
    logic [IdW-1:0]                     source_id;
  } anc_item_t;

  typedef struct packed {
    logic [NbrCount-1:0] edge_mask;
    logic [IndexW-1:0]   tile_index;
    logic                no_match;
  } anc_result_t;

endpackage

@@ rtl/anc_mask.sv @@
// ----------------------------------------------------------------------------
// anc_mask: neighbour comparison and mask construction
// Builds the four-sided or eight-sided mask of one tile.
// ----------------------------------------------------------------------------
module anc_mask (
  input  anc_pkg::anc_item_t            item_i,
  output logic [anc_pkg::NbrCount-1:0]  mask_o
);
  import anc_pkg::*;

  logic [NbrCount-1:0] match_eq;
  logic [NbrCount-1:0] source_eq;
  logic [NbrCount-1:0] blob_mask;

  always_comb begin
    for (int unsigned i = 0; i < NbrCount; i++) begin
      match_eq[i]  = item_i.inside_mask[i] && (item_i.nbr_ids[i] == item_i.match_id);
      source_eq[i] = item_i.inside_mask[i] && (item_i.nbr_ids[i] == item_i.source_id);
    end
  end

  // A corner survives only when both sides next to it are set.
  always_comb begin
    blob_mask        = source_eq;
    blob_mask[BitTl] = source_eq[BitTl] & source_eq[BitL] & source_eq[BitT];
    blob_mask[BitBl] = source_eq[BitBl] & source_eq[BitL] & source_eq[BitB];
    blob_mask[BitTr] = source_eq[BitTr] & source_eq[BitR] & source_eq[BitT];
    blob_mask[BitBr] = source_eq[BitBr] & source_eq[BitR] & source_eq[BitB];
  end

  always_comb begin
    case (item_i.kind)
      KIND_FOUR:  mask_o = {4'b0000, match_eq[3:0]};
      KIND_EIGHT: mask_o = (match_eq == '0) ? '1 : blob_mask;
      default:    mask_o = '0;
    endcase
  end

endmodule

@@ rtl/anc_decode.sv @@
// ----------------------------------------------------------------------------
// anc_decode: blob pattern decoder
// Maps a mask to its tile index, or passes the side nibble in four-sided mode.
// ----------------------------------------------------------------------------
module anc_decode (
  input  anc_pkg::anc_kind_e            kind_i,
  input  logic [anc_pkg::NbrCount-1:0]  mask_i,
  output anc_pkg::anc_result_t          result_o
);
  import anc_pkg::*;

  logic [IndexW-1:0] blob_index;
  logic              blob_miss;

  always_comb begin
    blob_miss = 1'b0;
    unique case (mask_i)
      8'd70:   blob_index = 6'd0;
      8'd206:  blob_index = 6'd1;
      8'd140:  blob_index = 6'd2;
      8'd103:  blob_index = 6'd3;
      8'd255:  blob_index = 6'd4;
      8'd157:  blob_index = 6'd5;
      8'd35:   blob_index = 6'd6;
      8'd59:   blob_index = 6'd7;
      8'd25:   blob_index = 6'd8;
      8'd2:    blob_index = 6'd9;
      8'd10:   blob_index = 6'd10;
      8'd8:    blob_index = 6'd11;
      8'd4:    blob_index = 6'd12;
      8'd5:    blob_index = 6'd13;
      8'd1:    blob_index = 6'd14;
      8'd0:    blob_index = 6'd15;
      8'd6:    blob_index = 6'd16;
      8'd142:  blob_index = 6'd17;
      8'd78:   blob_index = 6'd18;
      8'd12:   blob_index = 6'd19;
      8'd39:   blob_index = 6'd20;
      8'd191:  blob_index = 6'd21;
      8'd127:  blob_index = 6'd22;
      8'd29:   blob_index = 6'd23;
      8'd71:   blob_index = 6'd24;
      8'd223:  blob_index = 6'd25;
      8'd239:  blob_index = 6'd26;
      8'd141:  blob_index = 6'd27;
      8'd3:    blob_index = 6'd28;
      8'd27:   blob_index = 6'd29;
      8'd43:   blob_index = 6'd30;
      8'd9:    blob_index = 6'd31;
      8'd7:    blob_index = 6'd32;
      8'd159:  blob_index = 6'd33;
      8'd111:  blob_index = 6'd34;
      8'd13:   blob_index = 6'd35;
      8'd14:   blob_index = 6'd36;
      8'd63:   blob_index = 6'd37;
      8'd207:  blob_index = 6'd38;
      8'd11:   blob_index = 6'd39;
      8'd15:   blob_index = 6'd40;
      8'd95:   blob_index = 6'd41;
      8'd175:  blob_index = 6'd42;
      8'd79:   blob_index = 6'd43;
      8'd47:   blob_index = 6'd44;
      8'd143:  blob_index = 6'd45;
      8'd31:   blob_index = 6'd46;
      default: begin
        blob_index = '0;
        blob_miss  = 1'b1;
      end
    endcase
  end

  always_comb begin
    result_o.edge_mask = mask_i;
    case (kind_i)
      KIND_FOUR: begin
        result_o.tile_index = {2'b00, mask_i[3:0]};
        result_o.no_match   = 1'b0;
      end
      default: begin
        result_o.tile_index = blob_index;
        result_o.no_match   = blob_miss;
      end
    endcase
  end

endmodule

@@ rtl/autotile_neighbour_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// autotile_neighbour_classifier_unit: blob autotile neighbour classifier
// Each input word is registered in the item register, its result in the result
// register. Throughput: one word per cycle unless the output stalls; the path
// between the item and result registers holds eight-way id compares, corner
// gating and the pattern decoder.
// Reset (rst_ni low, asynchronous) empties both pipeline stages.
// ----------------------------------------------------------------------------
module autotile_neighbour_classifier_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, lowest bit up: top_id, right_id, bottom_id, left_id, top_left_id,
  // top_right_id, bottom_right_id, bottom_left_id, inside_mask, match_id,
  // source_id (8 bits each).
  input  logic [87:0] s_axis_tdata,
  // tuser: kind (0 four-sided, 1 eight-sided).
  input  logic        s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, lowest bit up: edge_mask (8), tile_index (6), two zero pad bits.
  output logic [15:0] m_axis_tdata,
  // tuser: no_match.
  output logic        m_axis_tuser
);
  import anc_pkg::*;

  // Stage one holds the raw input word; stage two holds the finished result.
  anc_item_t   item_d, item_q;
  logic        item_valid_q;
  anc_result_t result_d, result_q;
  logic        result_valid_q;

  logic [NbrCount-1:0] mask;
  logic                advance;
  logic                take_in;

  // The result register moves whenever it is empty or being drained, and the
  // input register refills in the same cycle, so a word enters every cycle
  // as long as the downstream side keeps up.
  assign advance       = !result_valid_q || m_axis_tready;
  assign s_axis_tready = !item_valid_q || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d.kind = anc_kind_e'(s_axis_tuser);
    for (int unsigned i = 0; i < NbrCount; i++) begin
      item_d.nbr_ids[i] = s_axis_tdata[IdW*i +: IdW];
    end
    item_d.inside_mask = s_axis_tdata[71:64];
    item_d.match_id    = s_axis_tdata[79:72];
    item_d.source_id   = s_axis_tdata[87:80];
  end

  anc_mask u_mask (
    .item_i (item_q),
    .mask_o (mask)
  );

  anc_decode u_decode (
    .kind_i   (item_q.kind),
    .mask_i   (mask),
    .result_o (result_d)
  );

  // Payload registers load without reset.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      item_q <= item_d;
    end
    if (advance && item_valid_q) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q   <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        item_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        result_valid_q <= item_valid_q;
      end
    end
  end

  assign m_axis_tvalid = result_valid_q;
  assign m_axis_tdata  = {2'b00, result_q.tile_index, result_q.edge_mask};
  assign m_axis_tuser  = result_q.no_match;

endmodule

@@ verif/blob_tile_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blob_tile_checker: scoreboard for the neighbour classifier
// Watches both streams. Every accepted input word is classified here.
// Every accepted result word is compared with the oldest pending tile.
// ----------------------------------------------------------------------------
module blob_tile_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [87:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,
  input  logic        m_axis_tuser_i,
  output int unsigned mismatches_o,
  output int unsigned tiles_due_o
);
  import anc_pkg::*;

  // Masks of the 47 blob tiles, in tile index order.
  localparam logic [7:0] BlobMask [47] = '{
    8'd70,  8'd206, 8'd140, 8'd103, 8'd255, 8'd157, 8'd35,  8'd59,  8'd25,  8'd2,
    8'd10,  8'd8,   8'd4,   8'd5,   8'd1,   8'd0,   8'd6,   8'd142, 8'd78,  8'd12,
    8'd39,  8'd191, 8'd127, 8'd29,  8'd71,  8'd223, 8'd239, 8'd141, 8'd3,   8'd27,
    8'd43,  8'd9,   8'd7,   8'd159, 8'd111, 8'd13,  8'd14,  8'd63,  8'd207, 8'd11,
    8'd15,  8'd95,  8'd175, 8'd79,  8'd47,  8'd143, 8'd31
  };

  anc_result_t tiles_due [$];
  int unsigned errs = 0;

  function automatic logic [7:0] hits_of(anc_item_t tile, logic [7:0] key);
    logic [7:0] hits;
    hits = '0;
    for (int n = 0; n < NbrCount; n++) begin
      hits[n] = tile.inside_mask[n] && (tile.nbr_ids[n] == key);
    end
    return hits;
  endfunction

  function automatic anc_result_t classify_tile(anc_item_t tile);
    anc_result_t res;
    logic [7:0]  m;
    logic        found;
    res   = '0;
    found = 1'b0;
    if (tile.kind == KIND_FOUR) begin
      m              = hits_of(tile, tile.match_id) & 8'h0F;
      res.edge_mask  = m;
      res.tile_index = IndexW'(m[3:0]);
      res.no_match   = 1'b0;
    end else begin
      if (hits_of(tile, tile.match_id) == '0) begin
        m = 8'hFF;
      end else begin
        m = hits_of(tile, tile.source_id);
        // A corner survives only when both sides that touch it are set.
        if (!(m[BitL] && m[BitT])) m[BitTl] = 1'b0;
        if (!(m[BitL] && m[BitB])) m[BitBl] = 1'b0;
        if (!(m[BitR] && m[BitT])) m[BitTr] = 1'b0;
        if (!(m[BitR] && m[BitB])) m[BitBr] = 1'b0;
      end
      res.edge_mask = m;
      for (int t = 0; t < 47; t++) begin
        if (!found && BlobMask[t] == m) begin
          res.tile_index = IndexW'(t);
          found          = 1'b1;
        end
      end
      res.no_match = !found;
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    anc_item_t   tile;
    anc_result_t want;
    if (!rst_ni) begin
      mismatches_o <= 0;
      tiles_due_o  <= 0;
    end else begin
      // Results first: a result passes the item and result registers, so it
      // never belongs to the word accepted at the same edge.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (tiles_due.size() == 0) begin
          $display("%0t: result word %h arrived with no tile pending", $time,
                   m_axis_tdata_i);
          errs++;
        end else begin
          want = tiles_due.pop_front();
          if (m_axis_tdata_i[7:0] !== want.edge_mask) begin
            $display("%0t: edge_mask expected %h actual %h", $time, want.edge_mask,
                     m_axis_tdata_i[7:0]);
            errs++;
          end
          if (m_axis_tdata_i[13:8] !== want.tile_index) begin
            $display("%0t: tile_index expected %0d actual %0d", $time,
                     want.tile_index, m_axis_tdata_i[13:8]);
            errs++;
          end
          if (m_axis_tuser_i !== want.no_match) begin
            $display("%0t: no_match expected %b actual %b", $time, want.no_match,
                     m_axis_tuser_i);
            errs++;
          end
          if (m_axis_tdata_i[15:14] !== 2'b00) begin
            $display("%0t: pad bits expected 00 actual %b", $time,
                     m_axis_tdata_i[15:14]);
            errs++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        tile.kind        = anc_kind_e'(s_axis_tuser_i);
        tile.nbr_ids     = s_axis_tdata_i[63:0];
        tile.inside_mask = s_axis_tdata_i[71:64];
        tile.match_id    = s_axis_tdata_i[79:72];
        tile.source_id   = s_axis_tdata_i[87:80];
        tiles_due.push_back(classify_tile(tile));
      end
      mismatches_o <= errs;
      tiles_due_o  <= int'(tiles_due.size());
    end
  end

endmodule

@@ verif/autotile_neighbour_classifier_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// autotile_neighbour_classifier_unit_tb: stream test of the tile classifier
// Sends a directed set of neighbourhoods, then random tiles built mostly from
// the match and source ids, with random gaps on both streams. A separate
// checker classifies every accepted word and compares the results.
// ----------------------------------------------------------------------------
module autotile_neighbour_classifier_unit_tb;
  import anc_pkg::*;

  localparam int unsigned RandomTiles = 1450;
  localparam int unsigned StallLimit  = 1000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  int unsigned mismatches;
  int unsigned tiles_due;
  int unsigned stall_cycles = 0;
  // While set, neither stream inserts gaps.
  logic        calm = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  autotile_neighbour_classifier_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  blob_tile_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .mismatches_o    (mismatches),
    .tiles_due_o     (tiles_due)
  );

  // The result side stalls at random, about 22 percent of the time.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 22);
    end
  end

  // Watchdog: too many cycles in a row without any word moving.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic anc_item_t make_tile(anc_kind_e kind, logic [63:0] ids,
                                          logic [7:0] in_grid, logic [7:0] match,
                                          logic [7:0] source);
    anc_item_t tile;
    tile.kind        = kind;
    tile.nbr_ids     = ids;
    tile.inside_mask = in_grid;
    tile.match_id    = match;
    tile.source_id   = source;
    return tile;
  endfunction

  // Random tile. Most neighbour ids are the match or the source id, so both
  // the existence test and the corner gating see rich patterns.
  function automatic anc_item_t random_tile();
    anc_item_t  tile;
    int unsigned pick;
    tile.kind      = ($urandom_range(3) != 0) ? KIND_EIGHT : KIND_FOUR;
    tile.match_id  = 8'($urandom);
    tile.source_id = ($urandom_range(3) == 0) ? tile.match_id : 8'($urandom);
    if ($urandom_range(9) == 0) begin
      // Pure noise: every field at random.
      tile.nbr_ids     = {$urandom, $urandom};
      tile.inside_mask = 8'($urandom);
      return tile;
    end
    for (int n = 0; n < NbrCount; n++) begin
      pick = $urandom_range(9);
      if (pick < 5)      tile.nbr_ids[n] = tile.source_id;
      else if (pick < 7) tile.nbr_ids[n] = tile.match_id;
      else               tile.nbr_ids[n] = 8'($urandom);
    end
    pick = $urandom_range(9);
    if (pick < 6)       tile.inside_mask = 8'hFF;
    else if (pick == 6) tile.inside_mask = 8'h00;
    else                tile.inside_mask = 8'($urandom);
    return tile;
  endfunction

  // Presents one word and returns at the edge that accepts it. Called right
  // after a rising edge, so every drive here lands on that edge.
  task automatic send_tile(anc_item_t tile);
    while (!calm && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tile.source_id, tile.match_id, tile.inside_mask, tile.nbr_ids};
    s_axis_tuser  <= tile.kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Holds the input stream off until every pending result has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tiles_due != 0) @(posedge clk_i);
  endtask

  task automatic send_directed();
    logic [63:0] ids;
    int unsigned corner_bit [4];
    int unsigned side_a [4];
    int unsigned side_b [4];
    corner_bit = '{BitTl, BitTr, BitBr, BitBl};
    side_a     = '{BitL, BitR, BitR, BitL};
    side_b     = '{BitT, BitT, BitB, BitB};
    // Four-sided: every side matches, none inside, only diagonals match,
    // and the id extremes.
    send_tile(make_tile(KIND_FOUR, {8{8'h5A}}, 8'hFF, 8'h5A, 8'h00));
    send_tile(make_tile(KIND_FOUR, {8{8'h5A}}, 8'h00, 8'h5A, 8'h5A));
    send_tile(make_tile(KIND_FOUR, {8{8'hFF}}, 8'hF0, 8'hFF, 8'hFF));
    send_tile(make_tile(KIND_FOUR, {{4{8'h33}}, {4{8'h00}}}, 8'hFF, 8'h33, 8'h00));
    send_tile(make_tile(KIND_FOUR, {8{8'h00}}, 8'h05, 8'h00, 8'hFF));
    // Eight-sided with no matching neighbour: outside the grid, or other ids.
    send_tile(make_tile(KIND_EIGHT, {8{8'h11}}, 8'h00, 8'h11, 8'h11));
    send_tile(make_tile(KIND_EIGHT, {8{8'h11}}, 8'hFF, 8'h22, 8'h33));
    // Full surround through the source compare.
    send_tile(make_tile(KIND_EIGHT, {8{8'h11}}, 8'hFF, 8'h11, 8'h11));
    // Source only on corners: all of them get cleared.
    send_tile(make_tile(KIND_EIGHT, {{4{8'h44}}, {4{8'h77}}}, 8'hFF, 8'h77, 8'h44));
    // Match only on a diagonal still passes the existence test.
    send_tile(make_tile(KIND_EIGHT, {8'h00, 8'h00, 8'h00, 8'h99, {4{8'h00}}},
                        8'hFF, 8'h99, 8'hFF));
    send_tile(make_tile(KIND_EIGHT, {8{8'hFF}}, 8'hFF, 8'hFF, 8'h00));
    send_tile(make_tile(KIND_EIGHT, {8{8'hA0}}, 8'hAA, 8'hA0, 8'hA0));
    // Each side alone from the source.
    for (int s = 0; s < 4; s++) begin
      ids             = {8{8'h21}};
      ids[8*s +: 8]   = 8'h12;
      send_tile(make_tile(KIND_EIGHT, ids, 8'hFF, 8'h21, 8'h12));
    end
    // Each corner together with both of its sides.
    for (int c = 0; c < 4; c++) begin
      ids                        = {8{8'h21}};
      ids[8*corner_bit[c] +: 8]  = 8'h12;
      ids[8*side_a[c] +: 8]      = 8'h12;
      ids[8*side_b[c] +: 8]      = 8'h12;
      send_tile(make_tile(KIND_EIGHT, ids, 8'hFF, 8'h21, 8'h12));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_directed();
    drain_results();

    for (int unsigned k = 0; k < RandomTiles; k++) begin
      // A long stretch without gaps on either stream.
      if (k == 500) calm <= 1'b1;
      if (k == 750) calm <= 1'b0;
      if (k == 1000) drain_results();
      send_tile(random_tile());
    end

    s_axis_tvalid <= 1'b0;
    while (tiles_due != 0) @(posedge clk_i);
    // Two-stage pipeline: the extra wait below catches any stray result.
    repeat (6) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/anc_pkg.sv
rtl/anc_mask.sv
rtl/anc_decode.sv
rtl/autotile_neighbour_classifier_unit.sv
verif/blob_tile_checker.sv
verif/autotile_neighbour_classifier_unit_tb.sv
